// ===== rtl/core/dkc_pkg.sv =====
// Shared types, codes and default sizes for the distinct key counter.
package dkc_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MIN_TABLE_DEF   = 32;
    localparam int KEY_BITS_DEF    = 32;

    localparam int COUNT_W     = 13;
    localparam int OUT_KEY_W   = 32;
    localparam int CLASS_W     = 4;
    localparam int KIND_W      = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MULT_W      = 32;
    localparam int LG_W        = 6;

    localparam logic [MULT_W-1:0] MULT_RESET = 32'd107;

    // Register byte addresses
    localparam logic [CFG_ADDR_W-1:0] REG_HASH_MULT = 3'd0;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOKUP,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic open;
        logic load_key;
        logic load_out;
        logic clear_step;
        logic lookup;
        logic probe_next;
        logic insert;
        logic set_ovf;
    } cmd_t;

    typedef struct packed {
        logic class_zero;
        logic slot_empty;
        logic key_match;
        logic probe_last;
        logic clear_last;
    } stat_t;

endpackage

// ===== rtl/core/dkc_ctrl.sv =====
// Controller state machine: request handshake, clearing sweep and probe sequencing.
module dkc_ctrl
    import dkc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic                in_class_nonzero,
    output logic                out_valid,
    input  logic                out_ready,
    input  stat_t               stat,
    output cmd_t                cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_kind)
                        KIND_START:
                        begin
                            cmd.open = 1'b1;
                            if (in_class_nonzero)
                                state_next = ST_CLEAR;
                        end
                        KIND_KEY:
                        begin
                            if (!stat.class_zero)
                            begin
                                cmd.load_key = 1'b1;
                                state_next   = ST_LOOKUP;
                            end
                        end
                        KIND_END:
                        begin
                            cmd.load_out   = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (stat.slot_empty)
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.key_match)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.probe_last)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/dkc_dpath.sv =====
// Datapath: hash multiplier, key table memory, probe and clear counters, running stats.
module dkc_dpath
    import dkc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MIN_TABLE   = MIN_TABLE_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MULT_W-1:0]    hash_mult,
    input  logic [OUT_KEY_W-1:0] in_key,
    input  logic [CLASS_W-1:0]   in_size_class,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic [COUNT_W-1:0]   distinct_count,
    output logic [OUT_KEY_W-1:0] min_key,
    output logic [OUT_KEY_W-1:0] max_key,
    output logic                 overflow
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int MIN_LG = $clog2(MIN_TABLE);
    localparam int WORD_W = KEY_BITS + 1;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [63:0]          key_in_ext;
    logic [KEY_BITS-1:0]  key_in;
    logic [63:0]          key_in_z;
    logic [2*IDX_W-1:0]   prod;
    logic [LG_W-1:0]      lg_raw;
    logic [LG_W-1:0]      lg_clamp;
    logic [IDX_W-1:0]     mask_new;

    logic [KEY_BITS-1:0]  key_reg;
    logic [IDX_W-1:0]     hash_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [IDX_W-1:0]     probe_reg;
    logic [IDX_W-1:0]     clr_reg;
    logic [IDX_W-1:0]     mask_reg;
    logic [WORD_W-1:0]    rd_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [KEY_BITS-1:0]  min_reg;
    logic [KEY_BITS-1:0]  max_reg;
    logic                 ovf_reg;
    logic                 class_zero_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [OUT_KEY_W-1:0] out_min_reg;
    logic [OUT_KEY_W-1:0] out_max_reg;
    logic                 out_ovf_reg;

    logic [IDX_W-1:0]     slot_next;
    logic [IDX_W-1:0]     raddr;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [WORD_W-1:0]    wdata;
    logic [63:0]          min_ext;
    logic [63:0]          max_ext;

    // Keys are taken modulo 2^KEY_BITS
    assign key_in_ext = 64'(in_key);
    assign key_in     = key_in_ext[KEY_BITS-1:0];
    assign key_in_z   = 64'(key_in);
    assign prod       = key_in_z[IDX_W-1:0] * hash_mult[IDX_W-1:0];

    // Table mask from the size class, clamped to the physical depth
    assign lg_raw   = LG_W'(MIN_LG) + LG_W'(in_size_class) - LG_W'(1);
    assign lg_clamp = (lg_raw > LG_W'(IDX_W)) ? LG_W'(IDX_W) : lg_raw;

    always_comb
    begin
        for (int i = 0; i < IDX_W; i++)
            mask_new[i] = (LG_W'(i) < lg_clamp);
    end

    assign slot_next = cmd.lookup ? (hash_reg & mask_reg)
                                  : ((slot_reg + IDX_W'(1)) & mask_reg);
    assign raddr     = slot_next;

    assign we    = cmd.clear_step || cmd.insert;
    assign waddr = cmd.clear_step ? clr_reg : slot_reg;
    assign wdata = cmd.clear_step ? '0 : {1'b1, key_reg};

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg  <= key_in;
            hash_reg <= prod[IDX_W-1:0];
        end
        if (cmd.lookup || cmd.probe_next)
            slot_reg <= slot_next;
        if (cmd.lookup)
            probe_reg <= '0;
        else if (cmd.probe_next)
            probe_reg <= probe_reg + IDX_W'(1);
        if (cmd.open)
        begin
            clr_reg  <= '0;
            mask_reg <= mask_new;
        end
        else if (cmd.clear_step)
            clr_reg <= clr_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            min_reg        <= '1;
            max_reg        <= '0;
            ovf_reg        <= 1'b0;
            class_zero_reg <= 1'b1;
        end
        else if (cmd.open)
        begin
            count_reg      <= '0;
            min_reg        <= '1;
            max_reg        <= '0;
            ovf_reg        <= 1'b0;
            class_zero_reg <= (in_size_class == '0);
        end
        else
        begin
            if (cmd.insert)
            begin
                count_reg <= count_reg + COUNT_W'(1);
                if (key_reg < min_reg)
                    min_reg <= key_reg;
                if (key_reg > max_reg)
                    max_reg <= key_reg;
            end
            if (cmd.set_ovf)
                ovf_reg <= 1'b1;
        end
    end

    assign min_ext = 64'(min_reg);
    assign max_ext = 64'(max_reg);

    // Result register, held until the downstream side takes it
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_count_reg <= count_reg;
            out_min_reg   <= (count_reg != '0) ? min_ext[OUT_KEY_W-1:0] : '0;
            out_max_reg   <= (count_reg != '0) ? max_ext[OUT_KEY_W-1:0] : '0;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign stat.class_zero = class_zero_reg;
    assign stat.slot_empty = !rd_reg[KEY_BITS];
    assign stat.key_match  = (rd_reg[KEY_BITS-1:0] == key_reg);
    assign stat.probe_last = (probe_reg == mask_reg);
    assign stat.clear_last = (clr_reg == mask_reg);

    assign distinct_count = out_count_reg;
    assign min_key        = out_min_reg;
    assign max_key        = out_max_reg;
    assign overflow       = out_ovf_reg;

endmodule

// ===== rtl/core/distinct_key_count_minmax.sv =====
// Top level of the distinct key counter with running minimum and maximum.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: key, size_class; tuser: kind
//  m_*     | out       | m_tvalid/m_tready  | tdata: distinct_count, min, max; tuser: ovf
//  APB     | in/out    | psel/penable/pready| hash_multiplier at byte address 0
//
// A key request passes the lookup state and then the probe state, where it stays for
// every further probe: the single read port of the key table gives one probe a cycle.
// A start request with a nonzero size class runs a clearing sweep over the table size of
// its class; the sweep writes one table entry a cycle, and no request is taken meanwhile.
// End and other requests finish on acceptance. Reset opens an empty cluster (class zero),
// so no clearing pass is needed after reset. A stalled result holds in the output
// register; the next request is taken in the same cycle that the result is taken.
module distinct_key_count_minmax
    import dkc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MIN_TABLE   = MIN_TABLE_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // [31:0] key, [35:32] size_class, rest zero
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // [12:0] distinct_count, [44:13] min_key,
                                             // [76:45] max_key, rest zero
    output logic                  m_tuser,   // [0] overflow

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [MULT_W-1:0]    hash_mult_reg;
    logic                 cfg_wr;
    logic                 sel_mult;
    cmd_t                 cmd;
    stat_t                stat;
    logic [COUNT_W-1:0]   distinct_count;
    logic [OUT_KEY_W-1:0] min_key;
    logic [OUT_KEY_W-1:0] max_key;
    logic                 overflow;

    // Register file: one register, word index taken from paddr[2]
    assign pready   = 1'b1;
    assign sel_mult = (paddr[2] == REG_HASH_MULT[2]);
    assign cfg_wr   = psel && penable && pwrite && pready && sel_mult;
    assign prdata   = sel_mult ? hash_mult_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_mult_reg <= MULT_RESET;
        else if (cfg_wr)
            hash_mult_reg <= pwdata;
    end

    // Sequencing: accept, clear sweep, lookup and probe loop
    dkc_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_kind          (s_tuser),
        .in_class_nonzero (s_tdata[35:32] != '0),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .stat             (stat),
        .cmd              (cmd)
    );

    // Table, hash and running statistics
    dkc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MIN_TABLE   (MIN_TABLE),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .hash_mult      (hash_mult_reg),
        .in_key         (s_tdata[31:0]),
        .in_size_class  (s_tdata[35:32]),
        .cmd            (cmd),
        .stat           (stat),
        .distinct_count (distinct_count),
        .min_key        (min_key),
        .max_key        (max_key),
        .overflow       (overflow)
    );

    assign m_tdata = {3'b000, max_key, min_key, distinct_count};
    assign m_tuser = overflow;

endmodule

// ===== rtl/core/dkc_chk.sv =====
// Port-level checker for the distinct key counter, bound to the top level.
module dkc_chk
    import dkc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [KIND_W-1:0] s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [79:0]       m_tdata,
    input logic              m_tuser
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    // A waiting result blocks new requests
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

    // An end request yields a result in the next cycle
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_END) |=> m_tvalid)
        else $error("end request without result");

    // An empty cluster reports zero min and max
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[12:0] == '0) |-> (m_tdata[76:13] == '0))
        else $error("nonzero bounds with zero count");

    // A nonempty cluster has min not above max
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[12:0] != '0) |-> (m_tdata[44:13] <= m_tdata[76:45]))
        else $error("min above max");

endmodule

bind distinct_key_count_minmax dkc_chk u_dkc_chk (.*);
